// ----- sv/assert_macros.svh -----
// assertion macros shared by the triangulator rtl
// no dependencies; checks drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OGT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");
`define OGT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");
`else
`define OGT_ASSERT(label, clk, rst_n, prop)
`define OGT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- sv/ogt_pkg.sv -----
// shared types and constants for the organized grid triangulator
// no dependencies
`default_nettype none
package ogt_pkg;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_POINTS = 1048576;
	localparam int CFG_W          = 11;
	localparam int WIDTH_W        = 14;   // holds any row width up to 8192
	localparam int IDX_W          = 20;
	localparam logic [CFG_W-1:0] ROW_WIDTH_RST = CFG_W'(1024);

	// one quad as it leaves the line store stage
	typedef struct packed {
		logic               br;
		logic               tl;
		logic               bl;
		logic               trig;
		logic [IDX_W-1:0]   p;
		logic [WIDTH_W-1:0] w;
	} quad_t;

	typedef struct packed {
		logic [IDX_W-1:0] v0;
		logic [IDX_W-1:0] v1;
		logic [IDX_W-1:0] v2;
	} tri_t;
endpackage
`default_nettype wire

// ----- sv/ogt_emit.sv -----
// triangle selection and two-entry result buffer
// depends on ogt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module ogt_emit (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     quad_valid,
	input  wire ogt_pkg::quad_t           quad,
	input  wire logic                     tr,
	output logic                          quad_ready,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [ogt_pkg::IDX_W-1:0]     corner_first,
	output logic [ogt_pkg::IDX_W-1:0]     corner_second,
	output logic [ogt_pkg::IDX_W-1:0]     corner_third,
	output logic                          last_of_point
);
	import ogt_pkg::*;

	logic             c_a, c_b, c_c, c_d;
	logic [IDX_W-1:0] itr, itl, ibl;
	logic [1:0]       tri_n;
	tri_t             first_tri, second_tri;
	tri_t             slot0_q, slot1_q;
	logic [1:0]       cnt_q;
	logic             room, load, take;
	tri_t             head;

	always_comb begin
		itr = quad.p - IDX_W'(quad.w);
		itl = itr - IDX_W'(1);
		ibl = quad.p - IDX_W'(1);
		c_a = quad.tl & tr & quad.bl;
		c_b = tr & quad.bl & quad.br;
		c_c = quad.tl & tr & ~quad.bl & quad.br;
		c_d = quad.tl & ~tr & quad.bl & quad.br;
		// a pairs only with b; b, c and d exclude each other
		if (!quad.trig) begin
			tri_n = 2'd0;
		end else begin
			tri_n = {1'b0, c_a} + {1'b0, c_b} + {1'b0, c_c} + {1'b0, c_d};
		end
		second_tri = '{v0: itr, v1: quad.p, v2: ibl};
		if (c_a) begin
			first_tri = '{v0: itl, v1: itr, v2: ibl};
		end else if (c_b) begin
			first_tri = '{v0: itr, v1: quad.p, v2: ibl};
		end else if (c_c) begin
			first_tri = '{v0: itl, v1: itr, v2: quad.p};
		end else begin
			first_tri = '{v0: itl, v1: quad.p, v2: ibl};
		end
	end

	assign take       = out_valid & out_ready;
	assign room       = (cnt_q == 2'd0) | ((cnt_q == 2'd1) & out_ready);
	assign quad_ready = (tri_n == 2'd0) | room;
	assign load       = quad_valid & (tri_n != 2'd0) & room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= tri_n;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (tri_n == 2'd2) begin
				slot0_q <= first_tri;
				slot1_q <= second_tri;
			end else begin
				slot1_q <= first_tri;
			end
		end
	end

	assign head          = (cnt_q == 2'd2) ? slot0_q : slot1_q;
	assign out_valid     = cnt_q != 2'd0;
	assign corner_first  = head.v0;
	assign corner_second = head.v1;
	assign corner_third  = head.v2;
	assign last_of_point = cnt_q == 2'd1;

	`OGT_NEVER(a_cnt_range, clk, arst_n, cnt_q == 2'd3)
	`OGT_ASSERT(a_pair_follows, clk, arst_n,
		take && !last_of_point |=> out_valid && last_of_point)
	`OGT_ASSERT(a_pair_loads, clk, arst_n,
		load && tri_n == 2'd2 |=> cnt_q == 2'd2)
endmodule
`default_nettype wire

// ----- sv/organized_grid_triangulator.sv -----
// a triangle is registered in the quad stage, then in the result buffer
// throughput: one point per cycle while the buffer has room; a point with
// two triangles holds it until both are taken; output port sets the rate
// reset: counters, neighbor bits and flags clear, row width returns to 1024;
// the line store is not cleared and needs no clearing pass
`default_nettype none
`include "assert_macros.svh"
module organized_grid_triangulator #(
	parameter int MAX_WIDTH  = ogt_pkg::DEF_MAX_WIDTH,
	parameter int MAX_POINTS = ogt_pkg::DEF_MAX_POINTS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [ogt_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic                     point_valid,
	input  wire logic                     frame_start,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [ogt_pkg::IDX_W-1:0]     corner_first,
	output logic [ogt_pkg::IDX_W-1:0]     corner_second,
	output logic [ogt_pkg::IDX_W-1:0]     corner_third,
	output logic                          last_of_point
);
	import ogt_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int PI_W  = $clog2(MAX_POINTS) + 1;
	localparam logic [WIDTH_W-1:0] W_MAX = WIDTH_W'(MAX_WIDTH);
	localparam logic [PI_W-1:0]    P_MAX = PI_W'(MAX_POINTS);

	logic [CFG_W-1:0]   rw_q;
	logic [COL_W-1:0]   col_q;
	logic               past_q;
	logic [PI_W-1:0]    pidx_q;
	logic               left_q;
	logic               seen_q;
	logic               s1_valid_q;
	quad_t              quad_s1;
	logic               above_s1;
	logic               quad_ready;
	logic               in_acc;
	logic [WIDTH_W-1:0] w_eff;
	logic [COL_W-1:0]   col;
	logic               past;
	logic [PI_W-1:0]    pidx;
	logic [WIDTH_W-1:0] col_next;
	logic               row_end;
	logic [PI_W+IDX_W-1:0] p_ext;
	logic               line_mem [MAX_WIDTH];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rw_q <= ROW_WIDTH_RST;
		end else if (cfg_valid) begin
			rw_q <= cfg_data;
		end
	end

	always_comb begin
		if (rw_q < CFG_W'(2)) begin
			w_eff = WIDTH_W'(2);
		end else if (WIDTH_W'(rw_q) > W_MAX) begin
			w_eff = W_MAX;
		end else begin
			w_eff = WIDTH_W'(rw_q);
		end
		col      = frame_start ? '0 : col_q;
		past     = frame_start ? 1'b0 : past_q;
		pidx     = frame_start ? '0 : pidx_q;
		col_next = WIDTH_W'({1'b0, col}) + WIDTH_W'(1);
		row_end  = col_next >= w_eff;
		p_ext    = {{IDX_W{1'b0}}, pidx};
	end

	assign in_acc   = in_valid & in_ready;
	assign in_ready = ~s1_valid_q | quad_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			past_q     <= 1'b0;
			pidx_q     <= '0;
			left_q     <= 1'b0;
			seen_q     <= 1'b0;
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= in_acc | (s1_valid_q & ~quad_ready);
			if (in_acc) begin
				seen_q <= 1'b1;
				left_q <= point_valid;
				if (row_end) begin
					col_q  <= '0;
					past_q <= 1'b1;
				end else begin
					col_q  <= col_next[COL_W-1:0];
					past_q <= past;
				end
				// index saturates at capacity
				pidx_q <= (pidx < P_MAX) ? pidx + PI_W'(1) : pidx;
			end
		end
	end

	// quad fields; the upper-left bit is the previous point's line store read
	always_ff @(posedge clk) begin
		if (in_acc) begin
			quad_s1.br   <= point_valid;
			quad_s1.tl   <= ~frame_start & seen_q & above_s1;
			quad_s1.bl   <= ~frame_start & left_q;
			quad_s1.trig <= past & (col != '0) & (pidx < P_MAX);
			quad_s1.p    <= p_ext[IDX_W-1:0];
			quad_s1.w    <= w_eff;
		end
	end

	// line store: read old value and write new one at the same column
	always_ff @(posedge clk) begin
		if (in_acc) begin
			above_s1      <= line_mem[col];
			line_mem[col] <= point_valid;
		end
	end

	ogt_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.quad_valid    (s1_valid_q),
		.quad          (quad_s1),
		.tr            (above_s1),
		.quad_ready    (quad_ready),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.corner_first  (corner_first),
		.corner_second (corner_second),
		.corner_third  (corner_third),
		.last_of_point (last_of_point)
	);

	`OGT_ASSERT(a_frame_restart, clk, arst_n,
		in_acc && frame_start |=> !past_q && pidx_q == PI_W'(1))
	`OGT_NEVER(a_pidx_cap, clk, arst_n, pidx_q > P_MAX)
	`OGT_NEVER(a_col_range, clk, arst_n, WIDTH_W'(col_q) >= W_MAX)
endmodule
`default_nettype wire
